// File: design/box_filter_3x3_edge_clamped_top_defines.svh
// Assertion macros for the box filter top level.
`ifndef BOX_FILTER_3X3_EDGE_CLAMPED_TOP_DEFINES_SVH
`define BOX_FILTER_3X3_EDGE_CLAMPED_TOP_DEFINES_SVH

// Check cons in the same cycle as ante.
`define BF3_CHECK_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bf3 check failed");

// Check cons in the cycle after ante.
`define BF3_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bf3 check failed");

`endif

// File: design/bf3_pkg.sv
// Shared types and constants of the 3x3 box filter.
`default_nettype none

package bf3_pkg;

	localparam int MAX_DIM_DEFAULT      = 1024;
	localparam int CHANNEL_BITS_DEFAULT = 16;
	localparam int FIELD_W              = 16;
	localparam int CFG_W                = 11;
	localparam int DIM_RESET_VALUE      = 64;
	localparam int QUEUE_DEPTH          = 4;

	typedef enum logic {
		CMD_PIXEL = 1'b0,
		CMD_DRAIN = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		DIV_ONE  = 2'd0,
		DIV_FOUR = 2'd1,
		DIV_SIX  = 2'd2,
		DIV_NINE = 2'd3
	} div_t;

	typedef struct packed {
		logic emit;
		logic last;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		div_t div;
	} ctl_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

`default_nettype wire

// File: design/bf3_queue.sv
// Request queue between the front classifier and the back filter pipeline.
`default_nettype none

module bf3_queue #(
	parameter int WIDTH = 1,
	parameter int DEPTH = bf3_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [WIDTH-1:0]  push_data,
	input  logic              pop,
	output logic [WIDTH-1:0]  pop_data,
	output bf3_pkg::q_stat_t  stat
);
	import bf3_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] rd_q;
	logic [PTR_W-1:0] wr_q;
	logic [CNT_W-1:0] count_q;

	assign pop_data   = slot_q[rd_q];
	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= '0;
			wr_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: design/bf3_front.sv
// Front end: image size register, stream position and classification of each request.
`default_nettype none

module bf3_front #(
	parameter int MAX_DIM      = bf3_pkg::MAX_DIM_DEFAULT,
	parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bf3_pkg::CFG_W-1:0]     image_dim,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic [bf3_pkg::FIELD_W-1:0]   red_in,
	input  logic [bf3_pkg::FIELD_W-1:0]   green_in,
	input  logic [bf3_pkg::FIELD_W-1:0]   blue_in,
	input  logic                          q_full,
	output logic                          push,
	output logic [3*CHANNEL_BITS-1:0]     push_pix,
	output logic [$clog2(MAX_DIM)-1:0]    push_col,
	output bf3_pkg::ctl_t                 push_ctl
);
	import bf3_pkg::*;

	localparam int AW      = $clog2(MAX_DIM);
	localparam int DW      = $clog2(MAX_DIM + 2);
	localparam int CW      = (DW > CFG_W) ? DW : CFG_W;
	localparam int DIM_RST = (DIM_RESET_VALUE > MAX_DIM) ? MAX_DIM : DIM_RESET_VALUE;

	logic [DW-1:0] dim_q;
	logic [DW-1:0] tr_q;
	logic [AW-1:0] tc_q;
	logic [DW-1:0] dim_new;
	logic [CW-1:0] cfg_ext;
	logic [DW-1:0] dm1;
	logic [DW-1:0] pr;
	logic [AW-1:0] pc;
	logic          col_wrap;
	logic          row_end;
	logic          frame_end;
	logic          cfg_take;

	assign cfg_ready = 1'b1;
	assign cfg_take  = cfg_valid && cfg_ready;
	assign in_ready  = !q_full;
	assign push      = in_valid && in_ready;
	assign push_col  = tc_q;
	assign push_pix  = (command == CMD_DRAIN) ? '0 :
		{red_in[CHANNEL_BITS-1:0], green_in[CHANNEL_BITS-1:0], blue_in[CHANNEL_BITS-1:0]};

	always_comb begin
		cfg_ext = CW'(image_dim);
		if (cfg_ext == '0) begin
			dim_new = DW'(1);
		end else if (cfg_ext > CW'(MAX_DIM)) begin
			dim_new = DW'(MAX_DIM);
		end else begin
			dim_new = DW'(cfg_ext);
		end
	end

	always_comb begin
		dm1       = dim_q - 1'b1;
		col_wrap  = (tc_q == '0);
		row_end   = (DW'(tc_q) == dm1);
		frame_end = (tr_q == dim_q + 1'b1);
		pr        = col_wrap ? tr_q - DW'(2) : tr_q - 1'b1;
		pc        = col_wrap ? AW'(dm1) : tc_q - 1'b1;

		push_ctl.emit     = (tr_q >= DW'(2)) || ((tr_q == DW'(1)) && !col_wrap);
		push_ctl.top_ok   = (pr != '0);
		push_ctl.bot_ok   = (pr != dm1);
		push_ctl.left_ok  = (pc != '0);
		push_ctl.right_ok = (DW'(pc) != dm1);
		push_ctl.last     = (pr == dm1) && (DW'(pc) == dm1);

		if (dim_q == DW'(1)) begin
			push_ctl.div = DIV_ONE;
		end else begin
			case ({push_ctl.top_ok && push_ctl.bot_ok, push_ctl.left_ok && push_ctl.right_ok})
				2'b00:   push_ctl.div = DIV_FOUR;
				2'b11:   push_ctl.div = DIV_NINE;
				default: push_ctl.div = DIV_SIX;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= DW'(DIM_RST);
			tr_q  <= '0;
			tc_q  <= '0;
		end else if (cfg_take) begin
			dim_q <= dim_new;
			tr_q  <= '0;
			tc_q  <= '0;
		end else if (push) begin
			if (frame_end) begin
				tr_q <= '0;
				tc_q <= '0;
			end else if (row_end) begin
				tr_q <= tr_q + 1'b1;
				tc_q <= '0;
			end else begin
				tc_q <= tc_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: design/bf3_back.sv
// Back end: line store, 3x3 window, masked sums, reciprocal divide and output register.
`default_nettype none

module bf3_back #(
	parameter int MAX_DIM      = bf3_pkg::MAX_DIM_DEFAULT,
	parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEFAULT
) (
	input  logic                                                   clk,
	input  logic                                                   arst_n,
	input  logic                                                   q_valid,
	input  logic [$bits(bf3_pkg::ctl_t)+$clog2(MAX_DIM)+3*CHANNEL_BITS-1:0] q_data,
	output logic                                                   q_pop,
	output logic                                                   out_valid,
	input  logic                                                   out_ready,
	output logic [bf3_pkg::FIELD_W-1:0]                            red_out,
	output logic [bf3_pkg::FIELD_W-1:0]                            green_out,
	output logic [bf3_pkg::FIELD_W-1:0]                            blue_out,
	output logic                                                   frame_last
);
	import bf3_pkg::*;

	localparam int CB = CHANNEL_BITS;
	localparam int PW = 3 * CB;
	localparam int AW = $clog2(MAX_DIM);
	localparam int HW = CB + 2;
	localparam int SW = CB + 4;
	localparam int K  = CB + 8;
	localparam int MW = K + 1;
	localparam int XW = SW + MW;
	localparam logic [MW-1:0] RECIP_ONE  = MW'(2 ** K);
	localparam logic [MW-1:0] RECIP_FOUR = MW'(2 ** (K - 2));
	localparam logic [MW-1:0] RECIP_SIX  = MW'(((2 ** K) + 5) / 6);
	localparam logic [MW-1:0] RECIP_NINE = MW'(((2 ** K) + 8) / 9);

	logic [2*PW-1:0] line_mem [MAX_DIM];

	logic [PW-1:0]   q_pix;
	logic [AW-1:0]   q_col;
	ctl_t            q_ctl;
	logic            adv;

	logic            valid_s1;
	logic [PW-1:0]   pix_s1;
	logic [AW-1:0]   col_s1;
	ctl_t            ctl_s1;
	logic [2*PW-1:0] rdraw_s1;
	logic            fwd_s1;
	logic [2*PW-1:0] fwdat_s1;
	logic [2*PW-1:0] rd_s1;
	logic [2*PW-1:0] wdata;

	logic [PW-1:0]   win_q [9];

	logic            valid_s2;
	ctl_t            ctl_s2;
	logic [HW-1:0]   hsum [3][3];

	logic            valid_s3;
	ctl_t            ctl_s3;
	logic [HW-1:0]   hs_s3 [3][3];
	logic [SW-1:0]   vsum [3];
	logic [MW-1:0]   recip;

	logic            valid_s4;
	logic            last_s4;
	logic [SW-1:0]   sum_s4 [3];
	logic [MW-1:0]   recip_s4;

	logic            valid_s5;
	logic            last_s5;
	logic [XW-1:0]   prod_s5 [3];

	logic            out_valid_q;
	logic            last_q;
	logic [FIELD_W-1:0] chan_q [3];

	assign q_pix = q_data[PW-1:0];
	assign q_col = q_data[PW +: AW];
	assign q_ctl = ctl_t'(q_data[PW+AW +: $bits(ctl_t)]);

	assign adv   = !out_valid_q || out_ready;
	assign q_pop = adv && q_valid;

	assign rd_s1 = fwd_s1 ? fwdat_s1 : rdraw_s1;
	assign wdata = {pix_s1, rd_s1[2*PW-1:PW]};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rdraw_s1 <= line_mem[q_col];
		end
		if (adv && valid_s1) begin
			line_mem[col_s1] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pix_s1   <= q_pix;
			col_s1   <= q_col;
			ctl_s1   <= q_ctl;
			fwd_s1   <= valid_s1 && (col_s1 == q_col);
			fwdat_s1 <= wdata;
		end
		if (adv) begin
			if (valid_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= rd_s1[PW-1:0];
				win_q[5] <= rd_s1[2*PW-1:PW];
				win_q[8] <= pix_s1;
			end
			ctl_s2   <= ctl_s1;
			ctl_s3   <= ctl_s2;
			hs_s3    <= hsum;
			sum_s4   <= vsum;
			recip_s4 <= recip;
			last_s4  <= ctl_s3.last;
			last_s5  <= last_s4;
			for (int k = 0; k < 3; k++) begin
				prod_s5[k] <= XW'(sum_s4[k]) * XW'(recip_s4);
				chan_q[k]  <= FIELD_W'(prod_s5[k][K +: CB]);
			end
			last_q <= last_s5;
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int k = 0; k < 3; k++) begin
				hsum[r][k] = HW'(win_q[r*3+1][k*CB +: CB])
					+ (ctl_s2.left_ok  ? HW'(win_q[r*3][k*CB +: CB])   : '0)
					+ (ctl_s2.right_ok ? HW'(win_q[r*3+2][k*CB +: CB]) : '0);
			end
		end
		for (int k = 0; k < 3; k++) begin
			vsum[k] = SW'(hs_s3[1][k])
				+ (ctl_s3.top_ok ? SW'(hs_s3[0][k]) : '0)
				+ (ctl_s3.bot_ok ? SW'(hs_s3[2][k]) : '0);
		end
		case (ctl_s3.div)
			DIV_ONE:  recip = RECIP_ONE;
			DIV_FOUR: recip = RECIP_FOUR;
			DIV_SIX:  recip = RECIP_SIX;
			DIV_NINE: recip = RECIP_NINE;
			default:  recip = RECIP_ONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			valid_s5    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2 && ctl_s2.emit;
			valid_s4    <= valid_s3;
			valid_s5    <= valid_s4;
			out_valid_q <= valid_s5;
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_last = last_q;
	assign red_out    = chan_q[2];
	assign green_out  = chan_q[1];
	assign blue_out   = chan_q[0];

endmodule

`default_nettype wire

// File: design/box_filter_3x3_edge_clamped_top.sv
// Top level of the streaming 3x3 edge-clamped box filter.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_valid/cfg_ready   image_dim
//   in       in         in_valid/in_ready     command, red_in, green_in, blue_in
//   out      out        out_valid/out_ready   red_out, green_out, blue_out, frame_last
//
// One request per clock sustained while the output is not stalled; the line store does one
// read-modify-write of a column address per cycle, which sets that rate.
// The request that completes a result passes the s1 to s5 stages and the output register.
// Reset clears the control state; the line store is not cleared and needs no clearing pass.
// A stalled output holds the back pipeline; the four-entry queue takes up to four more
// requests before in_ready drops.
`default_nettype none

`include "box_filter_3x3_edge_clamped_top_defines.svh"

module box_filter_3x3_edge_clamped_top #(
	parameter int MAX_DIM      = bf3_pkg::MAX_DIM_DEFAULT,
	parameter int CHANNEL_BITS = bf3_pkg::CHANNEL_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bf3_pkg::CFG_W-1:0]   image_dim,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [bf3_pkg::FIELD_W-1:0] red_in,
	input  logic [bf3_pkg::FIELD_W-1:0] green_in,
	input  logic [bf3_pkg::FIELD_W-1:0] blue_in,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [bf3_pkg::FIELD_W-1:0] red_out,
	output logic [bf3_pkg::FIELD_W-1:0] green_out,
	output logic [bf3_pkg::FIELD_W-1:0] blue_out,
	output logic                        frame_last
);
	import bf3_pkg::*;

	localparam int PW = 3 * CHANNEL_BITS;
	localparam int AW = $clog2(MAX_DIM);
	localparam int QW = $bits(ctl_t) + AW + PW;

	logic          q_push;
	logic          q_pop;
	logic [PW-1:0] f_pix;
	logic [AW-1:0] f_col;
	ctl_t          f_ctl;
	logic [QW-1:0] q_in;
	logic [QW-1:0] q_out;
	q_stat_t       q_stat;

	assign q_in = {f_ctl, f_col, f_pix};

	bf3_front #(
		.MAX_DIM      (MAX_DIM),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.image_dim (image_dim),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.q_full    (q_stat.full),
		.push      (q_push),
		.push_pix  (f_pix),
		.push_col  (f_col),
		.push_ctl  (f_ctl)
	);

	bf3_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.pop       (q_pop),
		.pop_data  (q_out),
		.stat      (q_stat)
	);

	bf3_back #(
		.MAX_DIM      (MAX_DIM),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (!q_stat.empty),
		.q_data     (q_out),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red_out    (red_out),
		.green_out  (green_out),
		.blue_out   (blue_out),
		.frame_last (frame_last)
	);

	`BF3_CHECK_NEXT(a_pop_frees_slot, q_pop && !q_push, in_ready)
	`BF3_CHECK_NOW(a_queue_state, 1'b1, !(q_stat.full && q_stat.empty))
	`BF3_CHECK_NOW(a_pop_when_free, !q_stat.empty && !out_valid, q_pop)

endmodule

`default_nettype wire
